// File: rtl/core/ptfa_pkg.sv
// shared types and constants for the partition table fit allocator
// no dependencies
`default_nettype none
package ptfa_pkg;
    localparam int SLOTS_DEF = 4;
    localparam int HEADER_DEF = 512;
    localparam int NAME_BITS_DEF = 16;

    // request codes
    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_CREATE_EXT = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;
    localparam logic [1:0] REQ_DELETE = 2'd3;

    // fit codes
    localparam logic [1:0] FIT_BEST = 2'd0;
    localparam logic [1:0] FIT_FIRST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_NAME_EXISTS = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_EXT_EXISTS = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_TOO_SMALL = 3'd6;
    localparam logic [2:0] ST_NO_GROW = 3'd7;

    // configuration register indexes
    localparam logic [0:0] CFG_DISK_FIT = 1'd0;
    localparam logic [0:0] CFG_DISK_SIZE = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_SCAN,
        S_DECIDE,
        S_RESP
    } t_state;

    // command to every cell
    typedef struct packed {
        logic        sort_en;   // odd-even sort step
        logic        sort_odd;  // odd phase
        logic        shift_en;  // rotate chain one position
        logic        wr_en;     // write new slot contents into cell holding id
        logic        del_en;    // clear cell holding id
        logic        rsz_en;    // update size of cell holding id
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: rtl/core/partition_table_fit_allocator.sv
// top level of the partition table fit allocator: cell chain plus command sequencer
// depends on ptfa_pkg and ptfa_cell
//
// A command is taken when i_start is high and o_busy low; its one result is on the
// result ports, marked by o_done, and cannot be stalled. The cells form a chain that
// is first sorted by (start, slot) with an odd-even transposition sort of SLOTS steps,
// then rotated SLOTS times past a hole scanner at the chain head, one hole per cycle.
// Inactive cells sort to the end of the chain.
`default_nettype none
module partition_table_fit_allocator #(
    parameter int SLOTS = ptfa_pkg::SLOTS_DEF,
    parameter int HEADER_BYTES = ptfa_pkg::HEADER_DEF,
    parameter int NAME_BITS = ptfa_pkg::NAME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_name_id,
    input  wire logic signed [31:0] i_amount,
    input  wire logic [1:0]  i_part_fit,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [30:0]      o_start_addr,
    output logic [1:0]       o_slot
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1) + 1;
    localparam int NAME_W = (NAME_BITS < 16) ? NAME_BITS : 16;

    // configuration
    logic [1:0]  r_disk_fit;
    logic [30:0] r_disk_size;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_fit  <= ptfa_pkg::FIT_FIRST;
            r_disk_size <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptfa_pkg::CFG_DISK_FIT:  r_disk_fit  <= i_cfg_data[1:0];
                ptfa_pkg::CFG_DISK_SIZE: r_disk_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched command
    logic [1:0]        r_req;
    logic [NAME_W-1:0] r_key;
    logic signed [32:0] r_amt;
    logic [1:0]        r_pfit;

    // cell chain
    ptfa_pkg::t_cell_ctl ctl;
    logic [SLOTS-1:0]    c_act, c_ext, swap_sel;
    logic [31:0]         c_start [SLOTS];
    logic [31:0]         c_size  [SLOTS];
    logic [1:0]          c_fit   [SLOTS];
    logic [NAME_W-1:0]   c_name  [SLOTS];
    logic [IDX_W-1:0]    c_id    [SLOTS];
    logic [IDX_W-1:0]    target;
    logic [31:0]         new_start, new_size;

    // cell a sorts before cell b: active first, then by start, then index
    function automatic logic cell_before(input logic aa, input logic [31:0] as,
                                         input logic [IDX_W-1:0] ai, input logic ba,
                                         input logic [31:0] bs, input logic [IDX_W-1:0] bi);
        logic r;
        if (aa != ba) r = aa;
        else if (as != bs) r = as < bs;
        else r = ai < bi;
        return r;
    endfunction

    // swap selection for the current sort phase
    always_comb begin
        swap_sel = '0;
        for (int k = 0; k + 1 < SLOTS; k++) begin
            if ((k[0] == ctl.sort_odd) &&
                cell_before(c_act[k+1], c_start[k+1], c_id[k+1],
                            c_act[k], c_start[k], c_id[k])) begin
                swap_sel[k]   = 1'b1;
                swap_sel[k+1] = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            localparam int UP = (g + 1) % SLOTS;
            localparam int DN = (g + SLOTS - 1) % SLOTS;
            // neighbor: rotate takes from above; sort takes the partner
            localparam int PAIR_EVEN = (g % 2 == 0) ? UP : DN;
            localparam int PAIR_ODD  = (g % 2 == 1) ? UP : DN;
            logic [$clog2(SLOTS)-1:0] nb;
            assign nb = ctl.shift_en ? IDX_W'(UP)
                      : (ctl.sort_odd ? IDX_W'(PAIR_ODD) : IDX_W'(PAIR_EVEN));
            ptfa_cell #(.IDX_W(IDX_W), .NAME_W(NAME_W)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_reset_id (IDX_W'(g)),
                .i_target   (target),
                .i_swap_sel (swap_sel[g]),
                .i_nb_active(c_act[nb]),
                .i_nb_start (c_start[nb]),
                .i_nb_size  (c_size[nb]),
                .i_nb_ext   (c_ext[nb]),
                .i_nb_fit   (c_fit[nb]),
                .i_nb_name  (c_name[nb]),
                .i_nb_id    (c_id[nb]),
                .i_new_start(new_start),
                .i_new_size (new_size),
                .i_new_ext  (r_req == ptfa_pkg::REQ_CREATE_EXT),
                .i_new_fit  (r_pfit),
                .i_new_name (r_key),
                .o_active   (c_act[g]),
                .o_start    (c_start[g]),
                .o_size     (c_size[g]),
                .o_ext      (c_ext[g]),
                .o_fit      (c_fit[g]),
                .o_name     (c_name[g]),
                .o_id       (c_id[g])
            );
        end
    endgenerate

    // sequencer
    ptfa_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    // scanner state
    logic [32:0] r_cur;          // running hole start
    logic        r_found;
    logic [32:0] r_faddr;
    logic [33:0] r_fsize;        // signed, -1 means none
    // name / slot facts gathered during scan
    logic        r_name_hit, r_ext_hit;
    logic [IDX_W-1:0] r_name_slot;
    logic [32:0] r_tstart, r_tsize;  // named slot
    logic        r_seen_t;           // named slot already passed in the scan
    logic        r_lim_ok;
    logic [32:0] r_limit;

    logic head_hole;
    logic [32:0] hs;
    logic signed [33:0] hsize;
    logic [32:0] en;
    logic fits;

    // hole at chain head during scan; last step is the disk end
    always_comb begin
        head_hole = (r_cnt < CNT_W'(SLOTS)) && c_act[0];
        hs = r_cur;
        if (head_hole) begin
            hsize = $signed({2'b00, c_start[0]}) - $signed({1'b0, r_cur});
        end else begin
            hsize = $signed({3'b000, r_disk_size}) - $signed({1'b0, r_cur});
        end
        en = {1'b0, c_start[0]} + {1'b0, c_size[0]};
        fits = (hsize >= $signed(r_amt[32:0]));
    end

    logic scan_live;
    assign scan_live = (r_cnt < CNT_W'(SLOTS)) ? c_act[0] : 1'b1;

    logic [IDX_W-1:0] free_slot;
    logic             free_any;
    always_comb begin
        free_slot = '0;
        free_any = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!c_act[i] && (!free_any || c_id[i] < free_slot)) begin
                free_slot = c_id[i];
                free_any = 1'b1;
            end
        end
    end

    logic [2:0]  res_status;
    logic [32:0] res_start;
    logic [IDX_W-1:0] res_slot;
    logic        res_wr, res_del, res_rsz;
    logic signed [34:0] nsize;
    logic        final_found;

    // decision from gathered facts
    always_comb begin
        res_status = ptfa_pkg::ST_OK;
        res_start = '0;
        res_slot = '0;
        res_wr = 1'b0;
        res_del = 1'b0;
        res_rsz = 1'b0;
        nsize = $signed({2'b00, r_tsize}) + $signed({{2{r_amt[32]}}, r_amt});
        final_found = (r_disk_fit == ptfa_pkg::FIT_WORST)
            ? (!r_fsize[33] && ($signed(r_fsize) >= $signed({r_amt[32], r_amt}))) : r_found;
        case (r_req)
            ptfa_pkg::REQ_CREATE, ptfa_pkg::REQ_CREATE_EXT: begin
                if (r_amt[32] || r_amt == '0) res_status = ptfa_pkg::ST_TOO_SMALL;
                else if (!final_found) res_status = ptfa_pkg::ST_NO_SPACE;
                else if (r_req == ptfa_pkg::REQ_CREATE_EXT && r_ext_hit)
                    res_status = ptfa_pkg::ST_EXT_EXISTS;
                else if (r_name_hit) res_status = ptfa_pkg::ST_NAME_EXISTS;
                else if (!free_any) res_status = ptfa_pkg::ST_TABLE_FULL;
                else begin
                    res_start = r_faddr;
                    res_slot = free_slot;
                    res_wr = 1'b1;
                end
            end
            ptfa_pkg::REQ_RESIZE: begin
                if (!r_name_hit) res_status = ptfa_pkg::ST_NOT_FOUND;
                else if (nsize <= 0) res_status = ptfa_pkg::ST_TOO_SMALL;
                else if ($signed({2'b00, r_tstart}) + nsize > $signed({2'b00, r_limit}))
                    res_status = ptfa_pkg::ST_NO_GROW;
                else begin
                    res_slot = r_name_slot;
                    res_rsz = 1'b1;
                end
            end
            default: begin
                if (!r_name_hit) res_status = ptfa_pkg::ST_NOT_FOUND;
                else begin
                    res_slot = r_name_slot;
                    res_del = 1'b1;
                end
            end
        endcase
    end

    assign new_start = res_start[31:0];
    assign new_size  = (r_req == ptfa_pkg::REQ_RESIZE) ? nsize[31:0] : r_amt[31:0];
    assign target    = res_slot;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptfa_pkg::S_IDLE:   if (i_start) n_state = ptfa_pkg::S_SORT;
            ptfa_pkg::S_SORT:   if (r_cnt == CNT_W'(SLOTS - 1)) n_state = ptfa_pkg::S_SCAN;
            ptfa_pkg::S_SCAN:   if (r_cnt == CNT_W'(SLOTS)) n_state = ptfa_pkg::S_DECIDE;
            ptfa_pkg::S_DECIDE: n_state = ptfa_pkg::S_RESP;
            ptfa_pkg::S_RESP:   n_state = ptfa_pkg::S_IDLE;
            default:            n_state = ptfa_pkg::S_IDLE;
        endcase
    end

    // outputs to the cells
    always_comb begin
        ctl = '0;
        case (r_state)
            ptfa_pkg::S_SORT: begin
                ctl.sort_en  = 1'b1;
                ctl.sort_odd = r_cnt[0];
            end
            ptfa_pkg::S_SCAN:   ctl.shift_en = (r_cnt < CNT_W'(SLOTS));
            ptfa_pkg::S_DECIDE: begin
                ctl.wr_en  = res_wr;
                ctl.del_en = res_del;
                ctl.rsz_en = res_rsz;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ptfa_pkg::S_IDLE);

    // sequencer registers and scan accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptfa_pkg::S_IDLE;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= (r_state == ptfa_pkg::S_DECIDE);
            if (r_state != n_state) r_cnt <= '0;
            else r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ptfa_pkg::S_IDLE) begin
            r_req  <= i_req_type;
            r_key  <= i_name_id[NAME_W-1:0];
            r_amt  <= {i_amount[31], i_amount};
            r_pfit <= i_part_fit;
            r_cur  <= 33'(HEADER_BYTES);
            r_found <= 1'b0;
            r_faddr <= '0;
            r_fsize <= '1;
            r_name_hit <= 1'b0;
            r_ext_hit <= 1'b0;
            r_name_slot <= '0;
            r_tstart <= '0;
            r_tsize <= '0;
            r_seen_t <= 1'b0;
            r_lim_ok <= 1'b0;
            r_limit <= '0;
        end else if (r_state == ptfa_pkg::S_SCAN) begin
            // the limit: first active cell after the named one, else disk end
            if (r_cnt == CNT_W'(SLOTS) && !r_lim_ok) r_limit <= {2'b00, r_disk_size};
            if (r_cnt < CNT_W'(SLOTS) && c_act[0]) begin
                if (en > r_cur) r_cur <= en;
                if (c_ext[0]) r_ext_hit <= 1'b1;
                if (r_seen_t && !r_lim_ok) begin
                    r_lim_ok <= 1'b1;
                    r_limit <= {1'b0, c_start[0]};
                end
                if (c_name[0] == r_key &&
                    (!r_name_hit || c_id[0] < r_name_slot)) begin
                    r_name_hit <= 1'b1;
                    r_name_slot <= c_id[0];
                    r_tstart <= {1'b0, c_start[0]};
                    r_tsize <= {1'b0, c_size[0]};
                    r_seen_t <= 1'b1;
                    r_lim_ok <= 1'b0;
                end
            end
            if (r_cnt <= CNT_W'(SLOTS) && scan_live && hsize > 0) begin
                case (r_disk_fit)
                    ptfa_pkg::FIT_FIRST: if (!r_found && fits) begin
                        r_found <= 1'b1;
                        r_faddr <= hs;
                    end
                    ptfa_pkg::FIT_BEST: if (fits && (!r_found ||
                                            hsize < $signed(r_fsize))) begin
                        r_found <= 1'b1;
                        r_faddr <= hs;
                        r_fsize <= hsize;
                    end
                    ptfa_pkg::FIT_WORST: if (hsize >= $signed(r_fsize)) begin
                        r_faddr <= hs;
                        r_fsize <= hsize;
                    end
                    default: ;
                endcase
            end
        end else if (r_state == ptfa_pkg::S_DECIDE) begin
            o_status     <= res_status;
            o_start_addr <= res_start[30:0];
            o_slot       <= 2'(res_slot);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/ptfa_cell.sv
// one table cell: holds a slot record and its index, can swap or shift with neighbors
// depends on ptfa_pkg
`default_nettype none
module ptfa_cell #(
    parameter int IDX_W = 2,
    parameter int NAME_W = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ptfa_pkg::t_cell_ctl i_ctl,
    input  wire logic [IDX_W-1:0]    i_reset_id,
    input  wire logic [IDX_W-1:0]    i_target,
    input  wire logic                i_swap_sel,  // this cell takes the neighbor value
    input  wire logic                i_nb_active,
    input  wire logic [31:0]         i_nb_start,
    input  wire logic [31:0]         i_nb_size,
    input  wire logic                i_nb_ext,
    input  wire logic [1:0]          i_nb_fit,
    input  wire logic [NAME_W-1:0]   i_nb_name,
    input  wire logic [IDX_W-1:0]    i_nb_id,
    input  wire logic [31:0]         i_new_start,
    input  wire logic [31:0]         i_new_size,
    input  wire logic                i_new_ext,
    input  wire logic [1:0]          i_new_fit,
    input  wire logic [NAME_W-1:0]   i_new_name,
    output logic                     o_active,
    output logic [31:0]              o_start,
    output logic [31:0]              o_size,
    output logic                     o_ext,
    output logic [1:0]               o_fit,
    output logic [NAME_W-1:0]        o_name,
    output logic [IDX_W-1:0]         o_id
);
    logic hit;
    assign hit = (o_id == i_target);

    // record update: sort swap, rotate, or a command write, delete or resize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_active <= 1'b0;
            o_start  <= '0;
            o_size   <= '0;
            o_ext    <= 1'b0;
            o_fit    <= '0;
            o_name   <= '0;
            o_id     <= i_reset_id;
        end else if ((i_ctl.sort_en && i_swap_sel) || i_ctl.shift_en) begin
            o_active <= i_nb_active;
            o_start  <= i_nb_start;
            o_size   <= i_nb_size;
            o_ext    <= i_nb_ext;
            o_fit    <= i_nb_fit;
            o_name   <= i_nb_name;
            o_id     <= i_nb_id;
        end else if (hit && i_ctl.wr_en) begin
            o_active <= 1'b1;
            o_start  <= i_new_start;
            o_size   <= i_new_size;
            o_ext    <= i_new_ext;
            o_fit    <= i_new_fit;
            o_name   <= i_new_name;
        end else if (hit && i_ctl.del_en) begin
            o_active <= 1'b0;
            o_start  <= '0;
            o_size   <= '0;
            o_ext    <= 1'b0;
            o_fit    <= '0;
            o_name   <= '0;
        end else if (hit && i_ctl.rsz_en) begin
            o_size   <= i_new_size;
        end
    end
endmodule
`default_nettype wire
